// ===== sv/sliding_window_max_core_assert.svh =====
// ---------------------------------------------------------------------------
// sliding window max assertion macros
// shared property templates for the checker of the sliding window max core
// ---------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_MAX_CORE_ASSERT_SVH
`define SLIDING_WINDOW_MAX_CORE_ASSERT_SVH

// same-cycle implication, disabled while reset is high
`define SWM_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled while reset is high
`define SWM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/swm_pkg.sv =====
// ---------------------------------------------------------------------------
// sliding window max package
// shared types and fixed widths of the sliding window max core
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package swm_pkg;

   // fixed field widths
   localparam int SAMPLE_WIDTH = 32;
   localparam int WL_WIDTH     = 7;

   typedef logic signed [SAMPLE_WIDTH-1:0] sample_type;
   typedef logic [WL_WIDTH-1:0]            wl_type;

   // controls from the sequencer to every cell of the chain
   typedef struct packed {
      logic shift_en;   // take neighbor's sample and valid bit
      logic scan_clr;   // drop the running maximum
      logic scan_en;    // one hop of the running maximum toward cell 0
      logic seq_clr;    // end of sequence, drop all valid bits
   } cell_ctrl_type;

endpackage

// ===== sv/swm_cell.sv =====
// ---------------------------------------------------------------------------
// sliding window max cell
// one stage of the sample chain: holds a sample and a running maximum that
// moves one cell toward the head in each scan cycle
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module swm_cell #(
   parameter int KW         = 7,
   parameter int CELL_INDEX = 0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  swm_pkg::cell_ctrl_type ctrl,
   input  logic [KW-1:0]         k_eff,
   input  swm_pkg::sample_type   value_prev,
   input  logic                  valid_prev,
   input  swm_pkg::sample_type   pmax_next,
   input  logic                  pvalid_next,
   output swm_pkg::sample_type   value,
   output logic                  valid,
   output swm_pkg::sample_type   pmax,
   output logic                  pvalid
);
   import swm_pkg::*;

   localparam logic [KW-1:0] IDX = KW'(CELL_INDEX);

   sample_type value_ff;
   logic       valid_ff;
   sample_type pmax_ff, pmax_in;
   logic       pvalid_ff, pvalid_in;
   logic       in_window;

   // sample storage, shifts away from the head on each request
   always_ff @(posedge clock) begin
      if (ctrl.shift_en) begin
         value_ff <= value_prev;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || ctrl.seq_clr) begin
         valid_ff <= 1'b0;
      end else if (ctrl.shift_en) begin
         valid_ff <= valid_prev;
      end
   end

   // merge own sample into the maximum coming from the tail side
   always_comb begin
      in_window = valid_ff && (IDX < k_eff);
      pmax_in   = pmax_next;
      pvalid_in = pvalid_next;
      if (in_window) begin
         pvalid_in = 1'b1;
         if (!(pvalid_next && (pmax_next > value_ff))) begin
            pmax_in = value_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.scan_en) begin
         pmax_ff <= pmax_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || ctrl.scan_clr) begin
         pvalid_ff <= 1'b0;
      end else if (ctrl.scan_en) begin
         pvalid_ff <= pvalid_in;
      end
   end

   assign value  = value_ff;
   assign valid  = valid_ff;
   assign pmax   = pmax_ff;
   assign pvalid = pvalid_ff;

endmodule

// ===== sv/swm_ctrl.sv =====
// ---------------------------------------------------------------------------
// sliding window max sequencer
// request handshake, window length register, sample count, scan timing and
// result handshake of the sliding window max core
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module swm_ctrl #(
   parameter int WINDOW_MAX = 64,
   parameter int KW         = $clog2(WINDOW_MAX + 1)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  swm_pkg::wl_type        csr_data,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic                   req_tlast,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic                   rsp_load,
   output logic                   rsp_last,
   output swm_pkg::cell_ctrl_type ctrl,
   output logic [KW-1:0]          k_eff
);
   import swm_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   state_type     state_ff, state_in;
   wl_type        wl_ff;
   logic [KW-1:0] seen_ff, seen_in, seen_inc;
   logic [KW-1:0] scan_cnt_ff, scan_cnt_in;
   logic          emit_ff, emit_in;
   logic          last_ff, last_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          can_load;

   // window length register
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         wl_ff <= WL_WIDTH'(1);
      end else if (csr_valid) begin
         wl_ff <= csr_data;
      end
   end

   // zero means one, long windows saturate at the chain length
   always_comb begin
      if (wl_ff == '0) begin
         k_eff = KW'(1);
      end else if (int'(wl_ff) > WINDOW_MAX) begin
         k_eff = KW'(WINDOW_MAX);
      end else begin
         k_eff = KW'(wl_ff);
      end
   end

   assign can_load = !rsp_valid_ff || rsp_tready;
   assign seen_inc = (seen_ff < KW'(WINDOW_MAX)) ? seen_ff + KW'(1) : seen_ff;

   // sequencer
   always_comb begin
      state_in      = state_ff;
      seen_in       = seen_ff;
      scan_cnt_in   = scan_cnt_ff;
      emit_in       = emit_ff;
      last_in       = last_ff;
      req_tready    = 1'b0;
      rsp_load      = 1'b0;
      ctrl          = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               ctrl.shift_en = 1'b1;
               ctrl.scan_clr = 1'b1;
               seen_in       = seen_inc;
               emit_in       = (seen_inc >= k_eff);
               last_in       = req_tlast;
               scan_cnt_in   = k_eff;
               state_in      = ST_SCAN;
            end
         end
         ST_SCAN: begin
            ctrl.scan_en = 1'b1;
            scan_cnt_in  = scan_cnt_ff - KW'(1);
            if (scan_cnt_ff == KW'(1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!emit_ff || can_load) begin
               rsp_load     = emit_ff;
               ctrl.seq_clr = last_ff;
               if (last_ff) begin
                  seen_in = '0;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // result valid flag of the output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         seen_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         seen_ff      <= seen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_cnt_ff <= scan_cnt_in;
      emit_ff     <= emit_in;
      last_ff     <= last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_last   = last_ff;

endmodule

// ===== sv/sliding_window_max_core.sv =====
// ---------------------------------------------------------------------------
// sliding window max core
// running maximum over the latest window_length signed samples of a sequence
// ---------------------------------------------------------------------------
// Channels: req_ carries one sample per request, tlast marks the last sample
// of a sequence. rsp_ carries one maximum per request once window_length
// samples of the sequence have arrived; tlast repeats the request's tlast.
// csr_ writes the window length (0 acts as 1, values above WINDOW_MAX act
// as WINDOW_MAX); write it only while no request is in flight.
// Timing: a request first shifts its sample into the cell chain, then the
// running maximum walks from cell K-1 back to cell 0 (K the effective window
// length), then the output register is loaded once it is free. The result
// shows on rsp_ in the same cycle that req_tready is high again.
// Stalls: the output register holds the result while rsp_tready is low; the
// next request is still taken and worked on, and only its result load waits.
// Reset: synchronous; clears the chain, the sample count and the output
// register, and sets the window length to 1. A request with tlast clears
// the chain after its result is loaded, so every sequence starts empty.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sliding_window_max_core #(
   parameter int WINDOW_MAX = 64
) (
   input  logic                clock,
   input  logic                reset,
   // configuration write
   input  logic                csr_valid,
   output logic                csr_ready,
   input  swm_pkg::wl_type     csr_data,     // [6:0] window_length
   // sample requests
   input  logic                req_tvalid,
   output logic                req_tready,
   input  swm_pkg::sample_type req_tdata,    // [31:0] sample
   input  logic                req_tlast,    // end_of_sequence
   // window maximum results
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output swm_pkg::sample_type rsp_tdata,    // [31:0] window_max
   output logic                rsp_tlast     // sequence_done
);
   import swm_pkg::*;

   localparam int KW = $clog2(WINDOW_MAX + 1);

   cell_ctrl_type ctrl;
   logic [KW-1:0] k_eff;
   logic          rsp_load, rsp_last;
   sample_type    rsp_max_ff;
   logic          rsp_last_ff;

   sample_type    cell_value [WINDOW_MAX];
   logic          cell_valid [WINDOW_MAX];
   sample_type    cell_pmax  [WINDOW_MAX];
   logic          cell_pvalid[WINDOW_MAX];

   // sequencer
   swm_ctrl #(
      .WINDOW_MAX (WINDOW_MAX),
      .KW         (KW)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_load   (rsp_load),
      .rsp_last   (rsp_last),
      .ctrl       (ctrl),
      .k_eff      (k_eff)
   );

   // cell chain, newest sample in cell 0
   for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
      sample_type v_prev;
      logic       vl_prev;
      sample_type p_next;
      logic       pv_next;

      if (i == 0) begin : g_head
         assign v_prev  = req_tdata;
         assign vl_prev = 1'b1;
      end else begin : g_body
         assign v_prev  = cell_value[i-1];
         assign vl_prev = cell_valid[i-1];
      end

      if (i == WINDOW_MAX - 1) begin : g_tail
         assign p_next  = '0;
         assign pv_next = 1'b0;
      end else begin : g_link
         assign p_next  = cell_pmax[i+1];
         assign pv_next = cell_pvalid[i+1];
      end

      swm_cell #(
         .KW         (KW),
         .CELL_INDEX (i)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .k_eff       (k_eff),
         .value_prev  (v_prev),
         .valid_prev  (vl_prev),
         .pmax_next   (p_next),
         .pvalid_next (pv_next),
         .value       (cell_value[i]),
         .valid       (cell_valid[i]),
         .pmax        (cell_pmax[i]),
         .pvalid      (cell_pvalid[i])
      );
   end

   // output register
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_max_ff  <= cell_pmax[0];
         rsp_last_ff <= rsp_last;
      end
   end

   assign rsp_tdata = rsp_max_ff;
   assign rsp_tlast = rsp_last_ff;

endmodule

// ===== sv/swm_checker.sv =====
// ---------------------------------------------------------------------------
// sliding window max checker
// port-level checks of the sliding window max core, bound to the top level
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sliding_window_max_core_assert.svh"

module swm_checker (
   input logic                clock,
   input logic                reset,
   input logic                csr_ready,
   input logic                req_tvalid,
   input logic                req_tready,
   input logic                rsp_tvalid,
   input logic                rsp_tready,
   input swm_pkg::sample_type rsp_tdata,
   input logic                rsp_tlast
);

   // a stalled result keeps its value
   `SWM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast), "result changed under stall")

   // one request at a time: busy on the cycle after an accept
   `SWM_ASSERT_NEXT(a_req_busy, clock, reset, req_tvalid && req_tready,
      !req_tready, "request taken while previous one in flight")

   // a fresh result is loaded only at the end of a request's work
   `SWM_ASSERT_NOW(a_rsp_after_work, clock, reset, $rose(rsp_tvalid),
      !$past(req_tready), "result appeared without a finished request")

   // configuration port never stalls
   `SWM_ASSERT_NOW(a_csr_ready, clock, reset, 1'b1, csr_ready,
      "configuration write stalled")

endmodule

bind sliding_window_max_core swm_checker u_swm_checker (.*);

// ===== bench/tb_top.sv =====
// ---------------------------------------------------------------------------
// sliding window max core testbench
// Drives signed samples in sequences through the core and compares each
// window maximum against a scoreboard that tracks its own copy of the cell
// chain, the sample count and the window length. The bench runs a short
// directed part, then random sequences over many window lengths, with
// random idle and stall bursts on both streams and a quiet tail at the end.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
   import swm_pkg::*;

   localparam int WINDOW_MAX    = 64;
   localparam int TOTAL_ITEMS   = 1250;
   localparam int CALM_ITEMS    = 150;
   localparam int SETTLE_CYCLES = WINDOW_MAX + 8;
   localparam int STALL_LIMIT   = 3000;

   typedef enum int {
      STYLE_RANDOM,
      STYLE_TIES,
      STYLE_FALLING,
      STYLE_RISING,
      STYLE_EXTREME
   } sample_style_type;

   typedef struct packed {
      sample_type window_max;
      logic       sequence_done;
   } window_result_type;

   // ------------------------------------------------------------------------
   // scoreboard: cell chain model and queue of expected maxima
   // ------------------------------------------------------------------------
   class window_max_scoreboard;
      sample_type        cell_value [WINDOW_MAX];
      bit                cell_valid [WINDOW_MAX];
      int unsigned       samples_seen;
      wl_type            window_length;
      window_result_type expected_q [$];
      int unsigned       mismatches;

      function new();
         clear_window();
         window_length = 1;
         mismatches    = 0;
      endfunction

      function void clear_window();
         for (int i = 0; i < WINDOW_MAX; i++) begin
            cell_value[i] = '0;
            cell_valid[i] = 1'b0;
         end
         samples_seen = 0;
      endfunction

      function void set_window_length(wl_type value);
         window_length = value;
      endfunction

      function int unsigned pending();
         return expected_q.size();
      endfunction

      // a request was accepted: shift it in and queue the maximum, if due
      function void note_sample(sample_type sample, logic last);
         int unsigned       k;
         sample_type        best;
         window_result_type res;
         if (window_length == 0)
            k = 1;
         else if (window_length > WINDOW_MAX)
            k = WINDOW_MAX;
         else
            k = window_length;
         for (int i = WINDOW_MAX - 1; i > 0; i--) begin
            cell_value[i] = cell_value[i-1];
            cell_valid[i] = cell_valid[i-1];
         end
         cell_value[0] = sample;
         cell_valid[0] = 1'b1;
         if (samples_seen < WINDOW_MAX)
            samples_seen++;
         if (samples_seen >= k) begin
            best = cell_value[0];
            for (int i = 1; i < k; i++) begin
               if (cell_valid[i] && cell_value[i] > best)
                  best = cell_value[i];
            end
            res.window_max    = best;
            res.sequence_done = last;
            expected_q.insert(expected_q.size(), res);
         end
         if (last)
            clear_window();
      endfunction

      // a result was accepted: compare with the oldest expectation
      function void check_result(sample_type got_max, logic got_done);
         window_result_type want;
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected window max: expected none, actual %0d done %b",
                     $time, got_max, got_done);
            mismatches++;
            return;
         end
         want = expected_q.pop_front();
         if (got_max !== want.window_max) begin
            $display("%0t: window_max error: expected %0d, actual %0d",
                     $time, want.window_max, got_max);
            mismatches++;
         end
         if (got_done !== want.sequence_done) begin
            $display("%0t: sequence_done error: expected %b, actual %b",
                     $time, want.sequence_done, got_done);
            mismatches++;
         end
      endfunction
   endclass

   logic       clock;
   logic       reset;
   logic       csr_valid;
   logic       csr_ready;
   wl_type     csr_data;
   logic       req_tvalid;
   logic       req_tready;
   sample_type req_tdata;
   logic       req_tlast;
   logic       rsp_tvalid;
   logic       rsp_tready;
   sample_type rsp_tdata;
   logic       rsp_tlast;

   window_max_scoreboard window_sb = new();

   bit            calm = 1'b0;
   int unsigned   gap_pct = 0;
   int unsigned   idle_cycles = 0;

   sliding_window_max_core #(
      .WINDOW_MAX(WINDOW_MAX)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // handshake monitor feeding the scoreboard
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready)
            window_sb.set_window_length(csr_data);
         if (req_tvalid && req_tready)
            window_sb.note_sample(req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready)
            window_sb.check_result(rsp_tdata, rsp_tlast);
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (reset || (csr_valid && csr_ready) || (req_tvalid && req_tready) ||
          (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // result side: stall bursts between ready stretches, none in the tail
   initial begin
      rsp_tready <= 1'b0;
      @(posedge clock);
      forever begin
         if (!calm && $urandom_range(0, 2) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         repeat ($urandom_range(1, 30)) @(posedge clock);
      end
   end

   // one sample request, with an optional idle burst ahead of it
   task automatic send_sample(input sample_type sample, input logic last);
      if (!calm && $urandom_range(0, 99) < gap_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= sample;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // let all results drain, then the block settle
   task automatic drain_block();
      req_tvalid <= 1'b0;
      while (window_sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // window length write, only with the block idle
   task automatic write_window(input wl_type value);
      drain_block();
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   // stimulus
   initial begin
      sample_type       extremes [4];
      sample_type       ramp_val;
      sample_type       s;
      sample_style_type style;
      wl_type           wl;
      wl_type           fixed_wl [7];
      int unsigned      k_eff;
      int unsigned      seq_left;
      int unsigned      items;
      int unsigned      phase;
      int unsigned      phase_items;

      extremes = '{32'sh7fffffff, sample_type'(32'h80000000), 32'sh0, -32'sh1};
      fixed_wl = '{7'd2, 7'd64, 7'd127, 7'd5, 7'd65, 7'd1, 7'd0};
      seq_left = 0;
      items    = 0;
      phase    = 0;
      ramp_val = '0;
      style    = STYLE_RANDOM;

      reset      <= 1'b1;
      csr_valid  <= 1'b0;
      csr_data   <= '0;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tlast  <= 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // window of one after reset: each request answers with itself
      send_sample(32'sh7fffffff, 1'b0);
      send_sample(sample_type'(32'h80000000), 1'b1);
      send_sample(32'sh0, 1'b0);
      send_sample(-32'sh1, 1'b0);
      send_sample(32'sh1, 1'b1);

      write_window(3);
      // sequence shorter than the window gives nothing, its end still clears
      send_sample(32'sh5, 1'b0);
      send_sample(32'sh6, 1'b1);
      // falling ramp keeps the maximum at the far end of the window
      send_sample(32'sh10, 1'b0);
      send_sample(32'sh9, 1'b0);
      send_sample(32'sh8, 1'b0);
      send_sample(32'sh7, 1'b1);
      // ties, then the most negative value filling the window
      send_sample(-32'sh2, 1'b0);
      send_sample(-32'sh2, 1'b0);
      send_sample(-32'sh2, 1'b0);
      send_sample(sample_type'(32'h80000000), 1'b0);
      send_sample(sample_type'(32'h80000000), 1'b0);
      send_sample(sample_type'(32'h80000000), 1'b1);

      // zero length acts as one; leave the sequence open
      write_window(0);
      send_sample(32'sh3, 1'b0);
      send_sample(sample_type'(32'h80000000), 1'b0);
      send_sample(32'sh4, 1'b0);
      send_sample(32'sh5, 1'b0);
      // new length applies over the cells already held
      write_window(2);
      send_sample(32'sh1, 1'b1);

      // random sequences over a spread of window lengths
      while (items < TOTAL_ITEMS) begin
         if (phase < 7)
            wl = fixed_wl[phase];
         else if ($urandom_range(0, 9) < 7)
            wl = wl_type'($urandom_range(1, 8));
         else if ($urandom_range(0, 2) != 0)
            wl = wl_type'($urandom_range(9, 40));
         else
            wl = wl_type'($urandom_range(0, 127));
         write_window(wl);
         k_eff = (wl == 0) ? 1 : ((wl > WINDOW_MAX) ? WINDOW_MAX : wl);
         case (phase % 3)
            0:       gap_pct = 0;
            1:       gap_pct = 15;
            default: gap_pct = 45;
         endcase
         phase_items = (k_eff >= 32) ? 160 : $urandom_range(60, 120);

         repeat (phase_items) begin
            if (items >= TOTAL_ITEMS)
               break;
            if (items >= TOTAL_ITEMS - CALM_ITEMS)
               calm = 1'b1;
            // plan a new sequence: mostly long enough to give results
            if (seq_left == 0) begin
               style    = sample_style_type'($urandom_range(0, 4));
               ramp_val = sample_type'($urandom);
               if ($urandom_range(0, 9) == 0)
                  seq_left = $urandom_range(1, k_eff);
               else
                  seq_left = k_eff + $urandom_range(0, 2 * k_eff + 4);
            end
            case (style)
               STYLE_RANDOM:  s = sample_type'($urandom);
               STYLE_TIES:    s = sample_type'($urandom_range(0, 6)) - 32'sd3;
               STYLE_FALLING: begin
                  ramp_val = ramp_val - sample_type'($urandom_range(0, 3));
                  s = ramp_val;
               end
               STYLE_RISING:  begin
                  ramp_val = ramp_val + sample_type'($urandom_range(0, 3));
                  s = ramp_val;
               end
               default:       s = extremes[$urandom_range(0, 3)];
            endcase
            seq_left--;
            send_sample(s, seq_left == 0);
            items++;
         end
         phase++;
      end

      drain_block();
      if (window_sb.mismatches == 0 && window_sb.pending() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
